FILE: rtl/pose_keyframe_selector_top_macros.svh
// Assertion macros for the pose keyframe selector.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef POSE_KEYFRAME_SELECTOR_TOP_MACROS_SVH
`define POSE_KEYFRAME_SELECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PKF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pkf_pkg.sv
// Shared types and constants of the pose keyframe selector.
// No dependencies; used by the interfaces, pkf_decide and the top level.
`timescale 1ns / 1ps

package pkf_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned QUAT_W  = 16;
    localparam int unsigned LIM_W   = 31;
    localparam int unsigned COS_W   = 16;
    localparam int unsigned LIMSQ_W = 2 * LIM_W;

    localparam logic [LIM_W-1:0]   DISTANCE_LIMIT_RST    = 31'd65536;
    localparam logic [LIMSQ_W-1:0] LIMIT_SQUARED_RST     = 62'h1_0000_0000;
    localparam logic [COS_W-1:0]   HALF_ANGLE_COSINE_RST = 16'd32727;

    typedef enum logic [0:0] {
        CFG_DISTANCE_LIMIT    = 1'b0,
        CFG_HALF_ANGLE_COSINE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [ID_W-1:0]          old_frame_id;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic                     end_of_run;
    } pose_t;

    // Position and orientation of the last kept pose.
    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } ref_t;

    // Thresholds as seen by the decision logic.
    typedef struct packed {
        logic [LIM_W-1:0]   distance_limit;
        logic [LIMSQ_W-1:0] limit_squared;
        logic [COS_W-1:0]   half_angle_cosine;
    } limits_t;

    typedef struct packed {
        logic            kept;
        logic [ID_W-1:0] source_id;
        logic [ID_W-1:0] new_id;
        logic            run_done;
    } result_t;

endpackage

FILE: rtl/pkf_if.sv
// Valid/ready channel interfaces for pose items and result items.
// Depends on pkf_pkg for field widths.
`timescale 1ns / 1ps

interface pkf_pose_if;
    logic                              valid;
    logic                              ready;
    logic [pkf_pkg::ID_W-1:0]          old_frame_id;
    logic signed [pkf_pkg::POS_W-1:0]  pos_x;
    logic signed [pkf_pkg::POS_W-1:0]  pos_y;
    logic signed [pkf_pkg::POS_W-1:0]  pos_z;
    logic signed [pkf_pkg::QUAT_W-1:0] quat_w;
    logic signed [pkf_pkg::QUAT_W-1:0] quat_x;
    logic signed [pkf_pkg::QUAT_W-1:0] quat_y;
    logic signed [pkf_pkg::QUAT_W-1:0] quat_z;
    logic                              end_of_run;

    modport source (
        output valid, old_frame_id, pos_x, pos_y, pos_z,
               quat_w, quat_x, quat_y, quat_z, end_of_run,
        input  ready
    );
    modport sink (
        input  valid, old_frame_id, pos_x, pos_y, pos_z,
               quat_w, quat_x, quat_y, quat_z, end_of_run,
        output ready
    );
endinterface

interface pkf_result_if;
    logic                     valid;
    logic                     ready;
    logic                     kept;
    logic [pkf_pkg::ID_W-1:0] source_id;
    logic [pkf_pkg::ID_W-1:0] new_id;
    logic                     run_done;

    modport source (
        output valid, kept, source_id, new_id, run_done,
        input  ready
    );
    modport sink (
        input  valid, kept, source_id, new_id, run_done,
        output ready
    );
endinterface

FILE: rtl/pkf_decide.sv
// Distance and rotation test of one pose against the reference pose.
// Depends on pkf_pkg; purely combinational, used by the top level.
`timescale 1ns / 1ps

module pkf_decide (
    input  pkf_pkg::pose_t   pose,
    input  pkf_pkg::ref_t    refp,
    input  pkf_pkg::limits_t lim,
    output logic             hit
);

    localparam int unsigned DW = pkf_pkg::POS_W + 1;
    localparam int unsigned SW = pkf_pkg::LIMSQ_W + 2;
    localparam int unsigned PW = 2 * pkf_pkg::QUAT_W;
    localparam int unsigned QW = PW + 2;

    logic signed [pkf_pkg::POS_W-1:0]  cur_p [3];
    logic signed [pkf_pkg::POS_W-1:0]  ref_p [3];
    logic signed [DW-1:0]              diff  [3];
    logic [DW-1:0]                     mag   [3];
    logic [pkf_pkg::LIMSQ_W-1:0]       sq    [3];
    logic [2:0]                        axis_far;
    logic [SW-1:0]                     sq_sum;
    logic                              too_far;

    logic signed [pkf_pkg::QUAT_W-1:0] cur_q [4];
    logic signed [pkf_pkg::QUAT_W-1:0] ref_q [4];
    logic signed [PW-1:0]              prod  [4];
    logic signed [QW-1:0]              dot;
    logic [QW-1:0]                     dot_mag;
    logic [QW-1:0]                     cos_thr;
    logic                              too_turned;

    assign cur_p = '{pose.pos_x, pose.pos_y, pose.pos_z};
    assign ref_p = '{refp.pos_x, refp.pos_y, refp.pos_z};
    assign cur_q = '{pose.quat_w, pose.quat_x, pose.quat_y, pose.quat_z};
    assign ref_q = '{refp.quat_w, refp.quat_x, refp.quat_y, refp.quat_z};

    // Square only the low bits: an axis past the limit decides on its own.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]     = DW'(cur_p[i]) - DW'(ref_p[i]);
            mag[i]      = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
            axis_far[i] = mag[i] > DW'(lim.distance_limit);
            sq[i]       = pkf_pkg::LIMSQ_W'(mag[i][pkf_pkg::LIM_W-1:0])
                        * pkf_pkg::LIMSQ_W'(mag[i][pkf_pkg::LIM_W-1:0]);
        end
    end

    assign sq_sum  = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    assign too_far = (|axis_far) || (sq_sum > SW'(lim.limit_squared));

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod[i] = PW'(cur_q[i]) * PW'(ref_q[i]);
        end
    end

    assign dot        = QW'(prod[0]) + QW'(prod[1]) + QW'(prod[2]) + QW'(prod[3]);
    assign dot_mag    = dot[QW-1] ? QW'(-dot) : QW'(dot);
    assign cos_thr    = {3'b000, lim.half_angle_cosine, 15'b0};
    assign too_turned = dot_mag < cos_thr;

    assign hit = too_far || too_turned;

endmodule

FILE: rtl/pose_keyframe_selector_top.sv
// Pose keyframe selector, top level: input register, decision, result register.
// Depends on pkf_pkg, pkf_if.sv, pkf_decide and the assertion macro header.
//
//   channel  | direction | handshake    | payload
//   ---------+-----------+--------------+------------------------------------------
//   pose     | in        | valid/ready  | old_frame_id, pos_x/y/z, quat_w/x/y/z, end_of_run
//   result   | out       | valid/ready  | kept, source_id, new_id, run_done
//   cfg      | in        | cfg_we only  | cfg_index, cfg_data
//
// One item per cycle while result.ready holds; input register, then result register.
// The decision and the reference update happen together as an item moves from the
// input register to the result register, so each item sees the previous one's state.
// A full result register that is not taken holds the input register; pose.ready
// then drops once the input register is also full.
// Reset: no run open, id counter zero, thresholds at their defaults; no clearing pass.
`timescale 1ns / 1ps
`include "pose_keyframe_selector_top_macros.svh"

module pose_keyframe_selector_top (
    input  logic                          clk,
    input  logic                          rst_n,
    pkf_pose_if.sink                      pose,
    pkf_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [pkf_pkg::LIM_W-1:0]     cfg_data
);

    logic                          in_valid_reg;
    pkf_pkg::pose_t                in_item_reg;
    pkf_pkg::pose_t                pose_in;
    logic                          out_valid_reg;
    pkf_pkg::result_t              out_item_reg;
    pkf_pkg::result_t              out_item_next;

    logic                          run_started_reg;
    logic                          run_started_next;
    logic [pkf_pkg::ID_W-1:0]      next_new_id_reg;
    logic [pkf_pkg::ID_W-1:0]      next_new_id_next;
    pkf_pkg::ref_t                 ref_reg;
    pkf_pkg::ref_t                 ref_next;
    pkf_pkg::limits_t              lim_reg;
    logic [pkf_pkg::LIMSQ_W-1:0]   cfg_square;

    logic                          advance;
    logic                          hit;
    logic                          take_ref;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign pose.ready = !in_valid_reg || advance;

    assign pose_in = '{
        old_frame_id: pose.old_frame_id,
        pos_x:        pose.pos_x,
        pos_y:        pose.pos_y,
        pos_z:        pose.pos_z,
        quat_w:       pose.quat_w,
        quat_x:       pose.quat_x,
        quat_y:       pose.quat_y,
        quat_z:       pose.quat_z,
        end_of_run:   pose.end_of_run
    };

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pose.ready)
        begin
            in_valid_reg <= pose.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pose.valid && pose.ready)
        begin
            in_item_reg <= pose_in;
        end
    end

    pkf_decide u_decide (
        .pose (in_item_reg),
        .refp (ref_reg),
        .lim  (lim_reg),
        .hit  (hit)
    );

    // Keep decision and state update for the item in the input register
    always_comb
    begin
        out_item_next           = '0;
        out_item_next.source_id = in_item_reg.old_frame_id;
        out_item_next.run_done  = in_item_reg.end_of_run;
        next_new_id_next        = next_new_id_reg;
        take_ref                = 1'b0;
        priority if (!run_started_reg)
        begin
            out_item_next.kept = 1'b1;
            take_ref           = 1'b1;
            next_new_id_next   = pkf_pkg::ID_W'(1);
        end
        else if (hit)
        begin
            out_item_next.kept   = 1'b1;
            out_item_next.new_id = next_new_id_reg;
            take_ref             = 1'b1;
            next_new_id_next     = next_new_id_reg + pkf_pkg::ID_W'(1);
        end
        else if (in_item_reg.end_of_run)
        begin
            // last pose of the run: keep it, but do not advance the counter
            out_item_next.kept   = 1'b1;
            out_item_next.new_id = next_new_id_reg;
        end
        else
        begin
            out_item_next.kept = 1'b0;
        end
        run_started_next = !in_item_reg.end_of_run;
        ref_next = take_ref ? pkf_pkg::ref_t'{
            pos_x:  in_item_reg.pos_x,
            pos_y:  in_item_reg.pos_y,
            pos_z:  in_item_reg.pos_z,
            quat_w: in_item_reg.quat_w,
            quat_x: in_item_reg.quat_x,
            quat_y: in_item_reg.quat_y,
            quat_z: in_item_reg.quat_z
        } : ref_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_started_reg <= 1'b0;
            next_new_id_reg <= '0;
            ref_reg         <= '0;
        end
        else if (advance)
        begin
            run_started_reg <= run_started_next;
            next_new_id_reg <= next_new_id_next;
            ref_reg         <= ref_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.kept      = out_item_reg.kept;
    assign result.source_id = out_item_reg.source_id;
    assign result.new_id    = out_item_reg.new_id;
    assign result.run_done  = out_item_reg.run_done;

    // Configuration; square the distance limit as it is written
    assign cfg_square = pkf_pkg::LIMSQ_W'(cfg_data) * pkf_pkg::LIMSQ_W'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.distance_limit    <= pkf_pkg::DISTANCE_LIMIT_RST;
            lim_reg.limit_squared     <= pkf_pkg::LIMIT_SQUARED_RST;
            lim_reg.half_angle_cosine <= pkf_pkg::HALF_ANGLE_COSINE_RST;
        end
        else if (cfg_we)
        begin
            unique case (pkf_pkg::cfg_index_t'(cfg_index))
                pkf_pkg::CFG_DISTANCE_LIMIT:
                begin
                    lim_reg.distance_limit <= cfg_data;
                    lim_reg.limit_squared  <= cfg_square;
                end
                pkf_pkg::CFG_HALF_ANGLE_COSINE:
                begin
                    lim_reg.half_angle_cosine <= cfg_data[pkf_pkg::COS_W-1:0];
                end
            endcase
        end
    end

    `PKF_ASSERT_NOW(a_dropped_has_no_id, clk, rst_n,
        result.valid && !result.kept, result.new_id == '0, "dropped item carries an id")
    `PKF_ASSERT_NOW(a_last_is_kept, clk, rst_n,
        result.valid && result.run_done, result.kept, "last pose of a run not kept")
    `PKF_ASSERT_NEXT(a_run_closes, clk, rst_n,
        advance && in_item_reg.end_of_run, !run_started_reg, "run still open after its end")
    `PKF_ASSERT_NEXT(a_first_id_zero, clk, rst_n,
        advance && !run_started_reg, next_new_id_reg == pkf_pkg::ID_W'(1),
        "id counter not restarted on a new run")

endmodule
